// File: rtl/jse_pkg.sv
// jse_pkg: shared types, unit constants and lookup functions for the json string escaper
// no dependencies; imported by jse_front, jse_queue, jse_back and json_string_escaper
package jse_pkg;

  localparam int UnitW = 16;
  localparam int QDepth = 2;
  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [UnitW-1:0] UNIT_QUOTE  = 16'h0022;
  localparam logic [UnitW-1:0] UNIT_BSLASH = 16'h005C;
  localparam logic [UnitW-1:0] UNIT_U      = 16'h0075;
  localparam logic [UnitW-1:0] CTRL_LIMIT  = 16'h0020;
  localparam logic [UnitW-1:0] SURR_LO     = 16'hD800;
  localparam logic [UnitW-1:0] HIGH_MAX    = 16'hDBFF;
  localparam logic [UnitW-1:0] LOW_MIN     = 16'hDC00;
  localparam logic [UnitW-1:0] SURR_HI     = 16'hDFFF;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_RAW,
    HELD_HEX
  } held_kind_t;

  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_RAW,
    CUR_ESC2,
    CUR_HEX
  } cur_kind_t;

  // one classified input item, expanded by the back end
  typedef struct packed {
    logic             open_q;
    held_kind_t       held_kind;
    logic [UnitW-1:0] held_val;
    cur_kind_t        cur_kind;
    logic [UnitW-1:0] cur_val;
    logic             close_q;
  } job_t;

  // second unit of a short escape, zero when the unit has none
  function automatic logic [UnitW-1:0] short_esc(input logic [UnitW-1:0] c);
    logic [UnitW-1:0] r;
    unique case (c)
      16'h0008: r = 16'h0062;
      16'h0009: r = 16'h0074;
      16'h000A: r = 16'h006E;
      16'h000C: r = 16'h0066;
      16'h000D: r = 16'h0072;
      16'h0022: r = 16'h0022;
      16'h005C: r = 16'h005C;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // lower-case hex digit as a code unit
  function automatic logic [UnitW-1:0] hex_digit(input logic [3:0] d);
    logic [UnitW-1:0] r;
    if (d < 4'd10) r = 16'h0030 + {12'd0, d};
    else r = 16'h0057 + {12'd0, d};
    return r;
  endfunction

  // unit idx of a \uXXXX escape of v
  function automatic logic [UnitW-1:0] hex_esc_unit(input logic [UnitW-1:0] v,
                                                    input logic [2:0] idx);
    logic [UnitW-1:0] r;
    unique case (idx)
      3'd0:    r = UNIT_BSLASH;
      3'd1:    r = UNIT_U;
      3'd2:    r = hex_digit(v[15:12]);
      3'd3:    r = hex_digit(v[11:8]);
      3'd4:    r = hex_digit(v[7:4]);
      default: r = hex_digit(v[3:0]);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/jse_front.sv
// jse_front: accepts input beats, tracks the held high surrogate, builds at most one job per beat
// depends on jse_pkg
module jse_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           code_unit,
  input  logic                  first_unit,
  input  logic                  last_unit,
  input  logic                  empty_string,
  input  logic                  q_full,
  output logic                  push,
  output jse_pkg::job_t         push_job
);
  import jse_pkg::*;

  logic             held_valid, held_valid_next;
  logic [UnitW-1:0] held_unit, held_unit_next;
  logic             accept;
  logic             eff_held, is_low, is_high;
  logic [UnitW-1:0] esc;
  job_t             job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    eff_held = held_valid && !first_unit;
    is_low   = (code_unit >= LOW_MIN) && (code_unit <= SURR_HI);
    is_high  = (code_unit >= SURR_LO) && (code_unit <= HIGH_MAX);
    esc      = short_esc(code_unit);

    job.open_q    = 1'b0;
    job.held_kind = HELD_NONE;
    job.held_val  = held_unit;
    job.cur_kind  = CUR_NONE;
    job.cur_val   = code_unit;
    job.close_q   = 1'b0;
    held_valid_next = 1'b0;
    held_unit_next  = '0;

    if (empty_string) begin
      job.open_q  = 1'b1;
      job.close_q = 1'b1;
    end else begin
      job.open_q  = first_unit;
      job.close_q = last_unit;
      if (eff_held && is_low) begin
        job.held_kind = HELD_RAW;
        job.cur_kind  = CUR_RAW;
      end else begin
        if (eff_held) job.held_kind = HELD_HEX;
        if (is_high && !last_unit) begin
          held_valid_next = 1'b1;
          held_unit_next  = code_unit;
        end else if (esc != '0) begin
          job.cur_kind = CUR_ESC2;
          job.cur_val  = esc;
        end else if ((code_unit < CTRL_LIMIT) || is_low || is_high) begin
          job.cur_kind = CUR_HEX;
        end else begin
          job.cur_kind = CUR_RAW;
        end
      end
    end
  end

  // beats that only fill the hold produce nothing downstream
  assign push = accept && (job.open_q || job.close_q || (job.held_kind != HELD_NONE) ||
                           (job.cur_kind != CUR_NONE));
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_unit  <= '0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      held_unit  <= held_unit_next;
    end
  end

endmodule

// File: rtl/jse_queue.sv
// jse_queue: short job queue between the front and back ends
// depends on jse_pkg
module jse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output jse_pkg::job_t head_job
);
  import jse_pkg::*;

  job_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign q_valid  = (count != '0);
  assign head_job = entries[rd_ptr];

  function automatic logic [QPtrW-1:0] inc_ptr(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (p == QPtrW'(QDepth - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr <= inc_ptr(wr_ptr);
      end
      if (pop) rd_ptr <= inc_ptr(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/jse_back.sv
// jse_back: expands queued jobs into output units, one per cycle while out_ready allows, into the output register
// depends on jse_pkg
module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  jse_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_unit,
  output logic          run_last,
  output logic          string_done
);
  import jse_pkg::*;

  typedef enum logic [1:0] {
    P_OPEN,
    P_HELD,
    P_CUR,
    P_CLOSE
  } phase_t;

  logic             act_valid;
  job_t             act;
  phase_t           phase;
  logic [2:0]       idx;

  logic             adv, last_in_phase, has_next, job_end;
  phase_t           nxt_phase;
  logic [2:0]       len;
  logic [UnitW-1:0] unit;

  function automatic phase_t first_phase(input job_t j);
    phase_t r;
    priority if (j.open_q) r = P_OPEN;
    else if (j.held_kind != HELD_NONE) r = P_HELD;
    else if (j.cur_kind != CUR_NONE) r = P_CUR;
    else r = P_CLOSE;
    return r;
  endfunction

  always_comb begin
    len  = 3'd1;
    unit = UNIT_QUOTE;
    unique case (phase)
      P_OPEN, P_CLOSE: begin
        len  = 3'd1;
        unit = UNIT_QUOTE;
      end
      P_HELD: begin
        if (act.held_kind == HELD_HEX) begin
          len  = 3'd6;
          unit = hex_esc_unit(act.held_val, idx);
        end else begin
          len  = 3'd1;
          unit = act.held_val;
        end
      end
      P_CUR: begin
        unique case (act.cur_kind)
          CUR_HEX: begin
            len  = 3'd6;
            unit = hex_esc_unit(act.cur_val, idx);
          end
          CUR_ESC2: begin
            len  = 3'd2;
            unit = (idx == 3'd0) ? UNIT_BSLASH : act.cur_val;
          end
          default: begin
            len  = 3'd1;
            unit = act.cur_val;
          end
        endcase
      end
      default: ;
    endcase

    has_next  = 1'b0;
    nxt_phase = P_CLOSE;
    unique case (phase)
      P_OPEN: begin
        priority if (act.held_kind != HELD_NONE) begin
          has_next = 1'b1; nxt_phase = P_HELD;
        end else if (act.cur_kind != CUR_NONE) begin
          has_next = 1'b1; nxt_phase = P_CUR;
        end else if (act.close_q) begin
          has_next = 1'b1; nxt_phase = P_CLOSE;
        end else begin
          has_next = 1'b0; nxt_phase = P_CLOSE;
        end
      end
      P_HELD: begin
        priority if (act.cur_kind != CUR_NONE) begin
          has_next = 1'b1; nxt_phase = P_CUR;
        end else if (act.close_q) begin
          has_next = 1'b1; nxt_phase = P_CLOSE;
        end else begin
          has_next = 1'b0; nxt_phase = P_CLOSE;
        end
      end
      P_CUR: begin
        if (act.close_q) begin
          has_next = 1'b1; nxt_phase = P_CLOSE;
        end
      end
      default: ;
    endcase
  end

  assign last_in_phase = (idx == len - 3'd1);
  assign adv     = act_valid && (!out_valid || out_ready);
  assign job_end = adv && last_in_phase && !has_next;
  // refill the active job when idle or right as its final unit leaves
  assign pop     = q_valid && (!act_valid || job_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid   <= 1'b0;
      act         <= '0;
      phase       <= P_OPEN;
      idx         <= '0;
      out_valid   <= 1'b0;
      out_unit    <= '0;
      run_last    <= 1'b0;
      string_done <= 1'b0;
    end else begin
      if (adv) begin
        out_valid   <= 1'b1;
        out_unit    <= unit;
        run_last    <= !has_next && last_in_phase;
        string_done <= (phase == P_CLOSE);
        if (!last_in_phase) begin
          idx <= idx + 3'd1;
        end else if (has_next) begin
          phase <= nxt_phase;
          idx   <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (!act_valid || job_end) begin
        act_valid <= q_valid;
      end
      if (pop) begin
        act   <= head_job;
        phase <= first_phase(head_job);
        idx   <= '0;
      end
    end
  end

endmodule

// File: rtl/json_string_escaper.sv
// json_string_escaper: top level, quotes and escapes a utf-16 string for json
// depends on jse_pkg, jse_front, jse_queue, jse_back
//
//   channel  signals                                                   dir
//   in       in_valid in_ready code_unit first_unit last_unit empty_string  in
//   out      out_valid out_ready out_unit run_last string_done            out
//
// a beat produces 0 to 13 output units, one per cycle while out_ready holds; the back end expander sets the rate
// a beat that yields one unit sustains one beat per cycle while out_ready holds; escapes stall input via in_ready
// with the queue empty and the back end idle, a job is queued, made active, then output
// reset clears the hold, the job queue, the active job and the output register
// input stalls only when the two-entry job queue is full
module json_string_escaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        first_unit,
  input  logic        last_unit,
  input  logic        empty_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_unit,
  output logic        run_last,
  output logic        string_done
);
  import jse_pkg::*;

  logic q_full, push, pop, q_valid;
  job_t push_job, head_job;

  jse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .first_unit   (first_unit),
    .last_unit    (last_unit),
    .empty_string (empty_string),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_unit    (out_unit),
    .run_last    (run_last),
    .string_done (string_done)
  );

`ifndef ASSERT_OFF
  a_close_ends_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("closing quote not last unit of its beat");

  a_close_is_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> out_unit == UNIT_QUOTE)
    else $error("closing unit is not a quote");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("job queue popped while empty");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job queue pushed while full");
`endif

endmodule
